// ===== src/fdbe_pkg.sv =====
// ----------------------------------------------------------------------------
// fdbe_pkg
// Shared sizes and types for the finite-difference back extrapolator.
// ----------------------------------------------------------------------------
package fdbe_pkg;

  // Longest sequence that enters the arithmetic.
  localparam int MAX_LEN    = 32;
  // Width of the internal wrapping arithmetic.
  localparam int DATA_WIDTH = 32;
  // Width of the sample and result fields on the ports.
  localparam int SAMPLE_W   = 32;

  // Sample counter holds 0..MAX_LEN; level address holds 0..MAX_LEN-1.
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_TAIL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

// ===== src/fdbe_ram.sv =====
// ----------------------------------------------------------------------------
// fdbe_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fdbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/finite_difference_back_extrapolator.sv =====
// ----------------------------------------------------------------------------
// finite_difference_back_extrapolator
// Newton forward-difference extrapolation of a sequence one step before start.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one item per sample, in_tdata the sample, in_tlast
//   set on the final sample of a sequence.
//   Output channel (out_*): one item per sequence, issued after the final
//   sample; out_tdata is the extrapolated value before the first sample,
//   out_tuser flags a sequence longer than MAX_LEN samples (result then built
//   from the first MAX_LEN samples only).
//   Timing: sample k of a sequence (counting from 0) is accepted, then walks
//   difference levels 0..k-1 through the level RAM (one read-modify-write per
//   cycle on its single read port and single write port), then stores the
//   new top level k and updates the sum, then finishes. Samples past MAX_LEN
//   go straight from accept to finish, outside the arithmetic.
//   The result is loaded into the output register at the end of the finish
//   cycle and is offered on out_tvalid from the next cycle on.
//   Reset: rst_n low clears the state, counter, sum, overflow flag and the
//   output valid flag. The level RAM needs no clearing: level j is always
//   written by the current sequence before its value is used.
//   Stall: the output register holds its item until taken. The block keeps
//   accepting samples while it waits and only holds in the finish step when
//   a second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module finite_difference_back_extrapolator (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [31:0] sample
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fdbe_pkg::SAMPLE_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  // out_tdata: [31:0] previous_value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fdbe_pkg::SAMPLE_W-1:0]  out_tdata,
  // out_tuser: [0] too_long
  output logic                           out_tuser
);

  import fdbe_pkg::*;

  state_t state_r, state_nxt;

  // Per-item working registers.
  data_t d_r, d_nxt;        // difference carried up the levels
  cnt_t  k_r, k_nxt;        // index of the sample being processed
  addr_t j_r, j_nxt;        // level being walked
  logic  last_r, last_nxt;

  // Per-sequence state.
  cnt_t  count_r, count_nxt;
  data_t sum_r, sum_nxt;
  logic  ovf_r, ovf_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt;

  // Level RAM ports.
  logic  ram_we;
  addr_t ram_waddr;
  data_t ram_wdata;
  addr_t ram_raddr;
  data_t ram_rdata;

  logic in_fire;
  logic walk_done;
  logic out_free;

  assign in_fire   = in_tvalid && in_tready;
  assign walk_done = (CNT_W'(j_r) + CNT_W'(1)) == k_r;
  assign out_free  = !out_valid_r || out_tready;

  fdbe_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = d_r;
    // Level 0 is read on accept; each walk step reads the level above.
    ram_raddr = (state_r == S_WALK) ? addr_t'(j_r + addr_t'(1)) : '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          d_nxt    = DATA_WIDTH'($signed(in_tdata));
          k_nxt    = count_r;
          j_nxt    = '0;
          last_nxt = in_tlast;
          if (count_r == cnt_t'(MAX_LEN)) begin
            // Sample past the limit: drop it from the arithmetic.
            ovf_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end else if (count_r == '0) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // Replace level j with the incoming difference, carry the new one up.
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = d_r;
        d_nxt     = d_r - ram_rdata;
        j_nxt     = addr_t'(j_r + addr_t'(1));
        if (walk_done) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        // Open level k and fold its leading difference into the sum.
        ram_we    = 1'b1;
        ram_waddr = k_r[ADDR_W-1:0];
        ram_wdata = d_r;
        sum_nxt   = k_r[0] ? (sum_r - d_r) : (sum_r + d_r);
        count_nxt = cnt_t'(k_r + cnt_t'(1));
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = SAMPLE_W'(sum_r);
          out_user_nxt  = ovf_r;
          count_nxt     = '0;
          sum_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== test/finite_difference_back_extrapolator_test.sv =====
// ----------------------------------------------------------------------------
// finite_difference_back_extrapolator_test
// Self-checking bench for the finite-difference back extrapolator.
// Sample sequences go into the stream input with random gaps. The results
// are taken with random backpressure. Each result is checked against an
// in-bench difference-table predictor. The stimulus covers single-sample
// sequences, field extremes, polynomial sequences, full-range noise, and
// sequences longer than MAX_LEN.
// ----------------------------------------------------------------------------
module finite_difference_back_extrapolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdbe_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int MAX_WAIT    = 18;
  localparam int DRAIN_CYCLES = 64;   // well above the time the longest sample occupies the block
  localparam int REPORT_MAX  = 10;

  // Random sequence flavors
  typedef enum int {
    SEQ_NOISE,      // full-range random samples
    SEQ_POLY,       // low-degree polynomial, built from a random difference vector
    SEQ_EXTREME     // samples drawn mostly from the corners of the range
  } seq_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                too_long;
  } extrap_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;
  logic                out_tuser;

  finite_difference_back_extrapolator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the latest entry of each difference level, the number of
  // samples that entered the arithmetic, the alternating sum and the overflow
  // flag.
  // --------------------------------------------------------------------------
  data_t       level_val [MAX_LEN];
  int unsigned depth_seen = 0;
  data_t       alt_sum = '0;
  bit          past_limit = 1'b0;

  sample_item_t pending_q[$];   // items waiting for the driver
  extrap_t      extrap_q[$];    // predicted results, oldest first
  int           err_cnt = 0;

  // Reset the predictor to its empty-sequence state.
  function automatic void clear_table();
    foreach (level_val[j]) level_val[j] = '0;
    depth_seen = 0;
    alt_sum    = '0;
    past_limit = 1'b0;
  endfunction

  // Fold one accepted sample into the difference table; queue a result on the
  // final sample.
  function automatic void absorb_sample(logic [SAMPLE_W-1:0] s, logic last);
    data_t  d;
    data_t  prev;
    extrap_t r;
    d = data_t'(signed'(s));
    if (depth_seen >= MAX_LEN) begin
      // Too long: the arithmetic ignores the sample, only the flag records it.
      past_limit = 1'b1;
    end else begin
      // Walk the wavefront: each level takes the new value, the difference
      // with its previous entry moves up a level.
      for (int j = 0; j < depth_seen; j++) begin
        prev         = level_val[j];
        level_val[j] = d;
        d            = d - prev;
      end
      level_val[depth_seen] = d;
      if (depth_seen % 2 == 1) alt_sum = alt_sum - d;
      else alt_sum = alt_sum + d;
      depth_seen++;
    end
    if (last) begin
      r.value    = alt_sum[SAMPLE_W-1:0];
      r.too_long = past_limit;
      extrap_q   = {extrap_q, r};
      clear_table();
    end
  endfunction

  function automatic void record_failure(string what);
    if (err_cnt < REPORT_MAX) $display("%0t ns: %s", $time, what);
    err_cnt++;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_item(logic [SAMPLE_W-1:0] s, logic last);
    sample_item_t it;
    it.sample = s;
    it.last   = last;
    pending_q = {pending_q, it};
  endfunction

  function automatic logic [SAMPLE_W-1:0] corner_sample();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Queue one sequence of the given length; the final sample carries the end mark.
  function automatic void queue_sequence(int len, seq_kind_t kind);
    logic [SAMPLE_W-1:0] diff [5];
    int                  degree;
    degree = $urandom_range(0, 4);
    foreach (diff[j]) diff[j] = (j <= degree) ? $urandom_range(0, 400) - 200 : 0;
    if ($urandom_range(0, 3) == 0) diff[0] = $urandom();
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_POLY: begin
          queue_item(diff[0], i == len - 1);
          // Advance the polynomial: each level absorbs the level above it.
          for (int j = 0; j < 4; j++) diff[j] = diff[j] + diff[j + 1];
        end
        SEQ_EXTREME: queue_item(corner_sample(), i == len - 1);
        default: queue_item($urandom(), i == len - 1);
      endcase
    end
  endfunction

  initial begin
    int        len;
    int        pick;
    seq_kind_t kind;
    clear_table();

    // Single-sample sequences: the result is the sample itself.
    queue_item(32'h7FFF_FFFF, 1'b1);
    queue_item(32'h8000_0000, 1'b1);
    queue_item(32'h0000_0000, 1'b1);
    queue_item(32'hFFFF_FFFF, 1'b1);
    // Opposite extremes: the first difference wraps.
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b1);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b1);
    // Squares 1, 4, 9, 16 extrapolate back to 0.
    queue_item(32'd1, 1'b0);
    queue_item(32'd4, 1'b0);
    queue_item(32'd9, 1'b0);
    queue_item(32'd16, 1'b1);
    // Alternating corners over several levels.
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h0000_0000, 1'b0);
    queue_item(32'h8000_0000, 1'b1);
    // Constant and linear runs.
    queue_item(32'hDEAD_BEEF, 1'b0);
    queue_item(32'hDEAD_BEEF, 1'b0);
    queue_item(32'hDEAD_BEEF, 1'b1);
    queue_item(32'hFFFF_FFFE, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b0);
    queue_item(32'h0000_0000, 1'b1);

    // Random sequences, mostly short, some filling all levels, a few too long.
    while (pending_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(1, 8);
      else if (pick < 87) len = $urandom_range(9, MAX_LEN - 1);
      else if (pick < 93) len = MAX_LEN;
      else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? SEQ_POLY : (pick < 7) ? SEQ_NOISE : SEQ_EXTREME;
      queue_sequence(len, kind);
    end

    // Hold reset low, then release it.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every result to come out, then let
    // the block settle to catch stray results.
    while (pending_q.size() != 0 || in_tvalid || extrap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("finite_difference_back_extrapolator test passed");
    end else begin
      $display("finite_difference_back_extrapolator test failed");
    end
    $finish;
  end

  // Limit: generous cap on the whole run.
  initial begin
    #4_000_000;
    $display("finite_difference_back_extrapolator test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the result
  // before predicting, so a spurious result never matches an item accepted
  // on the same edge.
  // --------------------------------------------------------------------------
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  always @(posedge clk) begin
    extrap_t exp_r;
    in_taken  <= rst_n && in_tvalid && (in_tready === 1'b1);
    out_taken <= rst_n && out_tready && (out_tvalid === 1'b1);

    if (rst_n && out_tready && out_tvalid === 1'b1) begin
      if (extrap_q.size() == 0) begin
        record_failure($sformatf("unexpected result: previous_value=%h too_long=%b",
                                 out_tdata, out_tuser));
      end else begin
        exp_r = extrap_q.pop_front();
        if (out_tdata !== exp_r.value)
          record_failure($sformatf("previous_value mismatch: expected %h, got %h",
                                   exp_r.value, out_tdata));
        if (out_tuser !== exp_r.too_long)
          record_failure($sformatf("too_long mismatch: expected %b, got %b",
                                   exp_r.too_long, out_tuser));
      end
    end

    if (rst_n && in_tvalid && in_tready === 1'b1) absorb_sample(in_tdata, in_tlast);
  end

  // --------------------------------------------------------------------------
  // Driver: present items from the pending queue at the falling edge, with a
  // random gap after each. Calm stretches drop the gaps entirely.
  // --------------------------------------------------------------------------
  int in_gap = 0;
  bit in_calm = 1'b0;

  always @(negedge clk) begin
    sample_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // Hold the item until the block takes it.
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      in_tlast  <= $urandom_range(0, 1);
    end else if (pending_q.size() != 0) begin
      it = pending_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= it.sample;
      in_tlast  <= it.last;
      if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
      in_gap = draw_wait(in_calm);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result side: after each taken result, stall for a random number of cycles.
  int out_stall = 0;
  bit out_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 12) == 0) out_calm = !out_calm;
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule
